@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

@@ hdl/mtep_pkg.sv @@
// ----------------------------------------------------------------------------
// MIDI track event parser package
// Shared codes, constants and transfer types.
// ----------------------------------------------------------------------------
`default_nettype none
package mtep_pkg;

   typedef enum logic [2:0] {
      PH_DELTA    = 3'd0,
      PH_STATUS   = 3'd1,
      PH_METATYPE = 3'd2,
      PH_LEN      = 3'd3,
      PH_DATA     = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_BAD_TRACK   = 3'd1,
      ST_BAD_STATUS  = 3'd2,
      ST_NO_RUNNING  = 3'd3,
      ST_PAST_END    = 3'd4,
      ST_LONG_VARLEN = 3'd5
   } status_type;

   typedef enum logic {
      OP_START = 1'b0,
      OP_BYTE  = 1'b1
   } op_type;

   localparam logic [7:0] STATUS_BIT  = 8'h80;
   localparam logic [7:0] DATA_MASK   = 8'h7f;
   localparam logic [7:0] SYSEX_F0    = 8'hf0;
   localparam logic [7:0] SYSEX_F7    = 8'hf7;
   localparam logic [7:0] META_FF     = 8'hff;
   localparam logic [3:0] HI_PROGRAM  = 4'hc;
   localparam logic [3:0] HI_PRESSURE = 4'hd;

   typedef struct packed {
      op_type      op;
      logic [3:0]  track;
      logic [31:0] track_length;
      logic [7:0]  data_byte;
      logic        bad_track;
   } item_type;

   typedef struct packed {
      logic [3:0]  out_track;
      logic [31:0] tick;
      logic [7:0]  event_byte;
      logic        first_of_event;
      logic        last_of_event;
      status_type  status;
   } rsp_type;

endpackage
`default_nettype wire

@@ hdl/mtep_front.sv @@
// ----------------------------------------------------------------------------
// MIDI track event parser front end
// Accepts input items, checks the track number and queues them.
// ----------------------------------------------------------------------------
`default_nettype none
module mtep_front
   import mtep_pkg::*;
#(
   parameter int MAX_TRACKS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output      logic        req_full,
   input  wire logic        req_op,
   input  wire logic [3:0]  req_track,
   input  wire logic [31:0] req_track_length,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic [4:0]  active_tracks,
   output      logic        item_valid,
   output      item_type    item,
   input  wire logic        item_pop
);
   item_type   q_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic       push, pop, bad;

   assign req_full   = (count_ff == 2'd2);
   assign push       = req_push && !req_full;
   assign item_valid = (count_ff != 2'd0);
   assign pop        = item_pop && item_valid;
   assign item       = q_ff[rd_ff];
   assign bad = ({1'b0, req_track} >= active_tracks) ||
                (32'(req_track) >= 32'(MAX_TRACKS));

   always_comb begin
      count_in = count_ff + 2'(push) - 2'(pop);
      wr_in    = wr_ff ^ push;
      rd_in    = rd_ff ^ pop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= '{op: op_type'(req_op), track: req_track,
                          track_length: req_track_length,
                          data_byte: req_data_byte, bad_track: bad};
      end
   end
endmodule
`default_nettype wire

@@ hdl/mtep_back.sv @@
// ----------------------------------------------------------------------------
// MIDI track event parser back end
// Per-track parse state; turns one item into up to two results a cycle when there is room.
// ----------------------------------------------------------------------------
`default_nettype none
module mtep_back
   import mtep_pkg::*;
#(
   parameter int MAX_TRACKS = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       item_valid,
   input  wire item_type   item,
   input  wire logic       room,
   output      logic       fire,
   output      logic [1:0] res_cnt,
   output      rsp_type    res0,
   output      rsp_type    res1
);
   localparam int TW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;

   phase_type   phase_ff   [MAX_TRACKS];
   logic [31:0] tick_ff    [MAX_TRACKS];
   logic [27:0] accum_ff   [MAX_TRACKS];
   logic [2:0]  vcnt_ff    [MAX_TRACKS];
   logic [7:0]  run_ff     [MAX_TRACKS];
   logic [31:0] remain_ff  [MAX_TRACKS];
   logic [31:0] consume_ff [MAX_TRACKS];
   logic [31:0] length_ff  [MAX_TRACKS];
   logic        halted_ff  [MAX_TRACKS];

   phase_type   phase_in;
   logic [31:0] tick_in, remain_in, consume_in;
   logic [27:0] accum_in, shifted;
   logic [2:0]  vcnt_in;
   logic [7:0]  run_in, c, run_cur;
   logic        halted_in, wr_state, wr_start;
   logic [TW-1:0] t;
   logic [32:0] sum;
   logic [3:0]  hi;
   logic [31:0] tk;

   assign fire = item_valid && room;
   assign t    = TW'(item.track);
   assign c    = item.data_byte;
   assign tk   = tick_ff[t];
   assign run_cur = run_ff[t];
   assign shifted = {accum_ff[t][20:0], c[6:0]};
   assign sum  = {1'b0, tk} + {5'd0, shifted};

   always_comb begin
      phase_in   = phase_ff[t];
      tick_in    = tk;
      accum_in   = accum_ff[t];
      vcnt_in    = vcnt_ff[t];
      run_in     = run_cur;
      remain_in  = remain_ff[t];
      consume_in = consume_ff[t] + 32'd1;
      halted_in  = halted_ff[t];
      wr_state   = 1'b0;
      wr_start   = 1'b0;
      res_cnt    = 2'd0;
      hi         = 4'd0;
      res0 = '{out_track: item.track, tick: tk, event_byte: c,
               first_of_event: 1'b0, last_of_event: 1'b0, status: ST_OK};
      res1 = res0;
      if (item.bad_track) begin
         res_cnt = 2'd1;
         res0.tick = '0;
         res0.event_byte = '0;
         res0.status = ST_BAD_TRACK;
      end else if (item.op == OP_START) begin
         wr_start = 1'b1;
      end else if (!halted_ff[t]) begin
         wr_state = 1'b1;
         res_cnt  = 2'd1;
         if (consume_ff[t] >= length_ff[t]) begin
            halted_in = 1'b1;
            consume_in = consume_ff[t];
            res0.event_byte = '0;
            res0.status = ST_PAST_END;
         end else begin
            unique case (phase_ff[t])
               PH_DELTA, PH_LEN: begin
                  if (c[7] && vcnt_ff[t] >= 3'd3) begin
                     halted_in = 1'b1;
                     res0.event_byte = '0;
                     res0.status = ST_LONG_VARLEN;
                  end else begin
                     accum_in = shifted;
                     vcnt_in  = vcnt_ff[t] + 3'd1;
                     if (phase_ff[t] == PH_DELTA) begin
                        res_cnt = 2'd0;
                        if (!c[7]) begin
                           tick_in  = sum[32] ? '1 : sum[31:0];
                           accum_in = '0;
                           vcnt_in  = '0;
                           phase_in = PH_STATUS;
                        end
                     end else if (!c[7]) begin
                        remain_in = {4'd0, shifted};
                        accum_in  = '0;
                        vcnt_in   = '0;
                        if (shifted == '0) begin
                           phase_in = PH_DELTA;
                           res0.last_of_event = 1'b1;
                        end else begin
                           phase_in = PH_DATA;
                        end
                     end
                  end
               end
               PH_STATUS: begin
                  res0.first_of_event = 1'b1;
                  if (c == META_FF) begin
                     run_in   = '0;
                     phase_in = PH_METATYPE;
                  end else if (c == SYSEX_F0 || c == SYSEX_F7) begin
                     run_in   = '0;
                     accum_in = '0;
                     vcnt_in  = '0;
                     phase_in = PH_LEN;
                  end else if (c[7]) begin
                     if (c > SYSEX_F0) begin
                        halted_in = 1'b1;
                        res0 = '{out_track: item.track, tick: tk, event_byte: '0,
                                 first_of_event: 1'b0, last_of_event: 1'b0,
                                 status: ST_BAD_STATUS};
                     end else begin
                        run_in    = c;
                        hi        = c[7:4];
                        remain_in = (hi == HI_PROGRAM || hi == HI_PRESSURE)
                                    ? 32'd1 : 32'd2;
                        phase_in  = PH_DATA;
                     end
                  end else if ((run_cur & STATUS_BIT) == '0) begin
                     halted_in = 1'b1;
                     res0 = '{out_track: item.track, tick: tk, event_byte: '0,
                              first_of_event: 1'b0, last_of_event: 1'b0,
                              status: ST_NO_RUNNING};
                  end else begin
                     hi = run_cur[7:4];
                     res_cnt = 2'd2;
                     res0.event_byte = run_cur;
                     if (hi == HI_PROGRAM || hi == HI_PRESSURE) begin
                        remain_in = '0;
                        phase_in  = PH_DELTA;
                        res1.last_of_event = 1'b1;
                     end else begin
                        remain_in = 32'd1;
                        phase_in  = PH_DATA;
                     end
                  end
               end
               PH_METATYPE: begin
                  accum_in = '0;
                  vcnt_in  = '0;
                  phase_in = PH_LEN;
               end
               PH_DATA: begin
                  if (remain_ff[t] != '0) begin
                     remain_in = remain_ff[t] - 32'd1;
                  end
                  if (remain_ff[t] <= 32'd1) begin
                     phase_in = PH_DELTA;
                     res0.last_of_event = 1'b1;
                  end
               end
               default: begin
                  phase_in = PH_DELTA;
                  res_cnt  = 2'd0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_TRACKS; i++) begin
            halted_ff[i] <= 1'b1;
         end
      end else if (fire && wr_start) begin
         halted_ff[t] <= 1'b0;
      end else if (fire && wr_state) begin
         halted_ff[t] <= halted_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && wr_start) begin
         phase_ff[t]   <= PH_DELTA;
         tick_ff[t]    <= '0;
         accum_ff[t]   <= '0;
         vcnt_ff[t]    <= '0;
         run_ff[t]     <= '0;
         remain_ff[t]  <= '0;
         consume_ff[t] <= '0;
         length_ff[t]  <= item.track_length;
      end else if (fire && wr_state) begin
         phase_ff[t]   <= phase_in;
         tick_ff[t]    <= tick_in;
         accum_ff[t]   <= accum_in;
         vcnt_ff[t]    <= vcnt_in;
         run_ff[t]     <= run_in;
         remain_ff[t]  <= remain_in;
         consume_ff[t] <= consume_in;
      end
   end
endmodule
`default_nettype wire

@@ hdl/mtep_rsp_fifo.sv @@
// ----------------------------------------------------------------------------
// MIDI track event parser result queue
// Four-entry queue taking up to two results per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module mtep_rsp_fifo
   import mtep_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire logic [1:0] push_cnt,
   input  wire rsp_type    din0,
   input  wire rsp_type    din1,
   output      logic       room,
   output      logic [2:0] count,
   output      logic       rsp_empty,
   input  wire logic       rsp_pop,
   output      rsp_type    dout
);
   rsp_type    mem_ff [4];
   logic [2:0] count_ff, count_in;
   logic [1:0] wr_ff, wr_in, rd_ff, rd_in, n;
   logic       pop;

   assign n         = push ? push_cnt : 2'd0;
   assign rsp_empty = (count_ff == 3'd0);
   assign pop       = rsp_pop && !rsp_empty;
   assign room      = (count_ff <= 3'd2);
   assign count     = count_ff;
   assign dout      = mem_ff[rd_ff];

   always_comb begin
      count_in = count_ff + 3'(n) - 3'(pop);
      wr_in    = wr_ff + n;
      rd_in    = rd_ff + 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         wr_ff    <= '0;
         rd_ff    <= '0;
      end else begin
         count_ff <= count_in;
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n != 2'd0) begin
         mem_ff[wr_ff] <= din0;
      end
      if (n == 2'd2) begin
         mem_ff[wr_ff + 2'd1] <= din1;
      end
   end
endmodule
`default_nettype wire

@@ hdl/midi_track_event_parser.sv @@
// ----------------------------------------------------------------------------
// MIDI track event parser
// Parses interleaved Standard MIDI File track chunks one byte at a time.
// ----------------------------------------------------------------------------
//  channel | ports              | transfer when
//  req     | push / full        | push && !full
//  rsp     | empty / pop        | pop && !empty
//  csr     | valid / ready      | valid && ready (ready always high)
//
// One item per cycle while the result queue has room. The back end needs two
// free result slots to take an item, since a running-status byte yields two
// results. Per-track state is read and written in the same cycle, so no
// forwarding is needed.
// Reset is synchronous; all tracks start halted until a start item.
// Stalls on rsp back up through the two-entry input queue to full.
`default_nettype none
`include "assert_macros.svh"
module midi_track_event_parser
   import mtep_pkg::*;
#(
   parameter int MAX_TRACKS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output      logic        req_full,
   input  wire logic        req_op,
   input  wire logic [3:0]  req_track,
   input  wire logic [31:0] req_track_length,
   input  wire logic [7:0]  req_data_byte,
   output      logic        rsp_empty,
   input  wire logic        rsp_pop,
   output      logic [3:0]  rsp_out_track,
   output      logic [31:0] rsp_tick,
   output      logic [7:0]  rsp_event_byte,
   output      logic        rsp_first_of_event,
   output      logic        rsp_last_of_event,
   output      logic [2:0]  rsp_status,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [4:0]  csr_active_tracks
);
   logic [4:0] active_ff, active_in;
   logic       item_valid, fire, room;
   item_type   item;
   logic [1:0] res_cnt;
   rsp_type    res0, res1, dout;
   logic [2:0] rsp_count;

   // configuration register; write it only while idle (the block does not enforce it)
   assign csr_ready = 1'b1;
   assign active_in = (csr_valid && csr_ready) ? csr_active_tracks : active_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 5'd1;
      end else begin
         active_ff <= active_in;
      end
   end

   mtep_front #(.MAX_TRACKS(MAX_TRACKS)) u_front (
      .clock, .reset, .req_push, .req_full, .req_op, .req_track,
      .req_track_length, .req_data_byte,
      .active_tracks(active_ff),
      .item_valid, .item, .item_pop(fire)
   );

   mtep_back #(.MAX_TRACKS(MAX_TRACKS)) u_back (
      .clock, .reset, .item_valid, .item, .room, .fire, .res_cnt, .res0, .res1
   );

   mtep_rsp_fifo u_rsp (
      .clock, .reset, .push(fire), .push_cnt(res_cnt), .din0(res0), .din1(res1),
      .room, .count(rsp_count), .rsp_empty, .rsp_pop, .dout
   );

   assign rsp_out_track      = dout.out_track;
   assign rsp_tick           = dout.tick;
   assign rsp_event_byte     = dout.event_byte;
   assign rsp_first_of_event = dout.first_of_event;
   assign rsp_last_of_event  = dout.last_of_event;
   assign rsp_status         = dout.status;

   `ASSERT_ALWAYS(a_rsp_bound, clock, reset, rsp_count <= 3'd4)
   `ASSERT_ALWAYS(a_fire_room, clock, reset, !fire || rsp_count <= 3'd2)
   `ASSERT_NEXT(a_pair_lands, clock, reset, fire && res_cnt == 2'd2, !rsp_empty)
endmodule
`default_nettype wire

@@ test/midi_track_event_parser_test.sv @@
// ----------------------------------------------------------------------------
// MIDI track event parser testbench
// Drives start and byte transfers for interleaved tracks, predicts each
// event byte and error result, and checks the result queue field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module midi_track_event_parser_test
   import mtep_pkg::*;
;

   localparam int NUM_TRACKS = 16;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [3:0]  out_track;
      logic [31:0] tick;
      logic [7:0]  event_byte;
      logic        first_of_event;
      logic        last_of_event;
      logic [2:0]  status;
   } event_out_type;

   typedef struct {
      op_type        op;
      logic [3:0]    track;
      logic [31:0]   track_length;
      logic [7:0]    data_byte;
      bit            has_golden;
      event_out_type golden;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic        req_op = 1'b0;
   logic [3:0]  req_track = '0;
   logic [31:0] req_track_length = '0;
   logic [7:0]  req_data_byte = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [3:0]  rsp_out_track;
   logic [31:0] rsp_tick;
   logic [7:0]  rsp_event_byte;
   logic        rsp_first_of_event;
   logic        rsp_last_of_event;
   logic [2:0]  rsp_status;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [4:0]  csr_active_tracks = 5'd1;

   // Per-track parser state kept by the predictor.
   logic [4:0]  tracks_enabled;
   phase_type   trk_phase   [NUM_TRACKS];
   logic [31:0] trk_tick    [NUM_TRACKS];
   logic [27:0] trk_vl_acc  [NUM_TRACKS];
   logic [2:0]  trk_vl_cnt  [NUM_TRACKS];
   logic [7:0]  trk_running [NUM_TRACKS];
   logic [31:0] trk_left    [NUM_TRACKS];
   logic [31:0] trk_used    [NUM_TRACKS];
   logic [31:0] trk_len     [NUM_TRACKS];
   bit          trk_halted  [NUM_TRACKS];

   event_out_type pending_events[$];
   int          error_count = 0;
   int          cycle_count = 0;
   int          events_seen = 0;
   int          items_sent = 0;
   bit          rx_idle_off = 1'b0;
   bit          tx_idle_off = 1'b0;

   midi_track_event_parser i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_op             (req_op),
      .req_track          (req_track),
      .req_track_length   (req_track_length),
      .req_data_byte      (req_data_byte),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_out_track      (rsp_out_track),
      .rsp_tick           (rsp_tick),
      .rsp_event_byte     (rsp_event_byte),
      .rsp_first_of_event (rsp_first_of_event),
      .rsp_last_of_event  (rsp_last_of_event),
      .rsp_status         (rsp_status),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_active_tracks  (csr_active_tracks)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic report(input string what);
      $display("mismatch @%0t: %s", $realtime, what);
      error_count++;
   endtask

   function automatic event_out_type mk(input logic [3:0] t, input logic [31:0] tk,
                                        input logic [7:0] b, input bit f,
                                        input bit l, input status_type s);
      event_out_type e;
      e.out_track = t; e.tick = tk; e.event_byte = b;
      e.first_of_event = f; e.last_of_event = l; e.status = s;
      return e;
   endfunction

   function automatic void clear_tracks();
      for (int t = 0; t < NUM_TRACKS; t++) begin
         trk_phase[t] = PH_DELTA; trk_tick[t] = '0; trk_vl_acc[t] = '0;
         trk_vl_cnt[t] = '0; trk_running[t] = '0; trk_left[t] = '0;
         trk_used[t] = '0; trk_len[t] = '0; trk_halted[t] = 1'b1;
      end
      tracks_enabled = 5'd1;
   endfunction

   function automatic void halt_with(input logic [3:0] t, input status_type s);
      trk_halted[t] = 1'b1;
      pending_events.push_back(mk(t, trk_tick[t], 8'h00, 0, 0, s));
   endfunction

   // Advance one track parser by one transfer; expected events are queued.
   function automatic void parse_item(input op_type op, input logic [3:0] t,
                                      input logic [31:0] len, input logic [7:0] c);
      logic [31:0] tk, sum;
      logic [3:0]  hi;
      if ({1'b0, t} >= tracks_enabled) begin
         pending_events.push_back(mk(t, '0, 8'h00, 0, 0, ST_BAD_TRACK));
         return;
      end
      if (op == OP_START) begin
         trk_phase[t] = PH_DELTA; trk_tick[t] = '0; trk_vl_acc[t] = '0;
         trk_vl_cnt[t] = '0; trk_running[t] = '0; trk_left[t] = '0;
         trk_used[t] = '0; trk_len[t] = len; trk_halted[t] = 1'b0;
         return;
      end
      if (trk_halted[t]) return;
      if (trk_used[t] >= trk_len[t]) begin
         halt_with(t, ST_PAST_END);
         return;
      end
      trk_used[t]++;
      tk = trk_tick[t];
      case (trk_phase[t])
         PH_DELTA, PH_LEN: begin
            if (c[7] && trk_vl_cnt[t] >= 3) begin
               halt_with(t, ST_LONG_VARLEN);
               return;
            end
            trk_vl_acc[t] = {trk_vl_acc[t][20:0], c[6:0]};
            trk_vl_cnt[t]++;
            if (trk_phase[t] == PH_DELTA) begin
               if (!c[7]) begin
                  sum = tk + trk_vl_acc[t];
                  trk_tick[t] = (sum < tk) ? 32'hffff_ffff : sum;
                  trk_vl_acc[t] = '0; trk_vl_cnt[t] = '0;
                  trk_phase[t] = PH_STATUS;
               end
            end else if (c[7]) begin
               pending_events.push_back(mk(t, tk, c, 0, 0, ST_OK));
            end else begin
               trk_left[t] = {4'd0, trk_vl_acc[t]};
               trk_vl_acc[t] = '0; trk_vl_cnt[t] = '0;
               trk_phase[t] = (trk_left[t] == 0) ? PH_DELTA : PH_DATA;
               pending_events.push_back(mk(t, tk, c, 0, trk_left[t] == 0, ST_OK));
            end
         end
         PH_STATUS: begin
            if (c == META_FF) begin
               trk_running[t] = '0;
               trk_phase[t] = PH_METATYPE;
               pending_events.push_back(mk(t, tk, c, 1, 0, ST_OK));
            end else if (c == SYSEX_F0 || c == SYSEX_F7) begin
               trk_running[t] = '0; trk_vl_acc[t] = '0; trk_vl_cnt[t] = '0;
               trk_phase[t] = PH_LEN;
               pending_events.push_back(mk(t, tk, c, 1, 0, ST_OK));
            end else if (c[7]) begin
               if (c > SYSEX_F0) begin
                  halt_with(t, ST_BAD_STATUS);
                  return;
               end
               trk_running[t] = c;
               hi = c[7:4];
               trk_left[t] = (hi == HI_PROGRAM || hi == HI_PRESSURE) ? 32'd1 : 32'd2;
               trk_phase[t] = PH_DATA;
               pending_events.push_back(mk(t, tk, c, 1, 0, ST_OK));
            end else if (!trk_running[t][7]) begin
               halt_with(t, ST_NO_RUNNING);
            end else begin
               // running status: stored status byte goes out first
               hi = trk_running[t][7:4];
               pending_events.push_back(mk(t, tk, trk_running[t], 1, 0, ST_OK));
               if (hi == HI_PROGRAM || hi == HI_PRESSURE) begin
                  trk_left[t] = '0; trk_phase[t] = PH_DELTA;
                  pending_events.push_back(mk(t, tk, c, 0, 1, ST_OK));
               end else begin
                  trk_left[t] = 32'd1; trk_phase[t] = PH_DATA;
                  pending_events.push_back(mk(t, tk, c, 0, 0, ST_OK));
               end
            end
         end
         PH_METATYPE: begin
            trk_vl_acc[t] = '0; trk_vl_cnt[t] = '0;
            trk_phase[t] = PH_LEN;
            pending_events.push_back(mk(t, tk, c, 0, 0, ST_OK));
         end
         PH_DATA: begin
            if (trk_left[t] > 0) trk_left[t]--;
            if (trk_left[t] == 0) trk_phase[t] = PH_DELTA;
            pending_events.push_back(mk(t, tk, c, 0, trk_left[t] == 0, ST_OK));
         end
         default: trk_phase[t] = PH_DELTA;
      endcase
   endfunction

   // Result side: random pop bursts, checks against the oldest expectation.
   initial begin
      int hold;
      event_out_type got, exp_ev;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            got = mk(rsp_out_track, rsp_tick, rsp_event_byte, rsp_first_of_event,
                     rsp_last_of_event, status_type'(rsp_status));
            events_seen++;
            if (pending_events.size() == 0) begin
               report($sformatf("unexpected result %p", got));
            end else begin
               exp_ev = pending_events.pop_front();
               if (got.out_track != exp_ev.out_track)
                  report($sformatf("track %0d want %0d", got.out_track, exp_ev.out_track));
               if (got.tick != exp_ev.tick)
                  report($sformatf("tick %0h want %0h", got.tick, exp_ev.tick));
               if (got.event_byte != exp_ev.event_byte)
                  report($sformatf("byte %0h want %0h", got.event_byte,
                                   exp_ev.event_byte));
               if (got.first_of_event != exp_ev.first_of_event)
                  report($sformatf("first %0b want %0b", got.first_of_event,
                                   exp_ev.first_of_event));
               if (got.last_of_event != exp_ev.last_of_event)
                  report($sformatf("last %0b want %0b", got.last_of_event,
                                   exp_ev.last_of_event));
               if (got.status != exp_ev.status)
                  report($sformatf("status %0d want %0d", got.status, exp_ev.status));
            end
         end
         if (hold > 0) begin
            hold--;
            rsp_pop <= 1'b0;
         end else if (!rx_idle_off && $urandom_range(0, 7) == 0) begin
            hold = $urandom_range(1, 9);
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // One input transfer, predicted once it is taken; golden results are checked by the caller.
   task automatic send(input op_type op, input logic [3:0] t, input logic [31:0] len,
                       input logic [7:0] c);
      int gap;
      if (!tx_idle_off && $urandom_range(0, 9) == 0) begin
         gap = $urandom_range(1, 9);
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_op <= op;
      req_track <= t;
      req_track_length <= len;
      req_data_byte <= c;
      do @(posedge clock); while (req_full);
      parse_item(op, t, len, c);
      items_sent++;
   endtask

   task automatic drain();
      req_push <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_tracks(input logic [4:0] n);
      csr_valid <= 1'b1;
      csr_active_tracks <= n;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      tracks_enabled = n;
   endtask

   // Directed rows: golden values where they are plain from the spec.
   stim_row_type directed[$];

   function automatic void row(input op_type op, input logic [3:0] t,
                               input logic [31:0] len, input logic [7:0] c,
                               input bit g = 0, input event_out_type ge = '0);
      stim_row_type r;
      r.op = op; r.track = t; r.track_length = len; r.data_byte = c;
      r.has_golden = g; r.golden = ge;
      directed.push_back(r);
   endfunction

   // Random well-formed event bytes for one track, with rare corruption.
   task automatic random_event(input logic [3:0] t);
      logic [7:0] st;
      int n, k;
      k = $urandom_range(0, 19);
      // delta time, sometimes multi-byte or large
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) send(OP_BYTE, t, $urandom, 8'h80 | 8'($urandom));
      send(OP_BYTE, t, $urandom, 8'($urandom_range(0, 127)));
      if (k == 0) begin
         send(OP_BYTE, t, $urandom, 8'($urandom));                // noise
      end else if (k < 4) begin
         send(OP_BYTE, t, $urandom, META_FF);
         send(OP_BYTE, t, $urandom, 8'($urandom));
         n = $urandom_range(0, 3);
         send(OP_BYTE, t, $urandom, 8'(n));
         for (int i = 0; i < n; i++) send(OP_BYTE, t, $urandom, 8'($urandom));
      end else if (k < 6) begin
         send(OP_BYTE, t, $urandom, ($urandom_range(0, 1) != 0) ? SYSEX_F0 : SYSEX_F7);
         n = $urandom_range(1, 3);
         send(OP_BYTE, t, $urandom, 8'h80);
         send(OP_BYTE, t, $urandom, 8'(n));
         for (int i = 0; i < n; i++) send(OP_BYTE, t, $urandom, 8'($urandom));
      end else if (k < 12) begin
         st = 8'($urandom_range(8'h80, 8'hef));
         send(OP_BYTE, t, $urandom, st);
         n = (st[7:4] == HI_PROGRAM || st[7:4] == HI_PRESSURE) ? 1 : 2;
         for (int i = 0; i < n; i++) send(OP_BYTE, t, $urandom, 8'($urandom_range(0, 127)));
      end else begin
         // running status data byte
         send(OP_BYTE, t, $urandom, 8'($urandom_range(0, 127)));
         if (trk_phase[t] == PH_DATA)
            send(OP_BYTE, t, $urandom, 8'($urandom_range(0, 127)));
      end
   endtask

   initial begin
      int ntr;
      logic [3:0] t;
      clear_tracks();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // After reset: one track, all halted.
      row(OP_BYTE, 4'd0, 32'd0, 8'h00);                          // halted, ignored
      row(OP_BYTE, 4'd15, 32'd0, 8'hff, 1, mk(15, 0, 0, 0, 0, ST_BAD_TRACK));
      row(OP_START, 4'd1, 32'hffff_ffff, 8'h00, 1, mk(1, 0, 0, 0, 0, ST_BAD_TRACK));
      row(OP_START, 4'd0, 32'hffff_ffff, 8'h00);
      row(OP_BYTE, 4'd0, 32'd0, 8'h00);                          // delta 0
      row(OP_BYTE, 4'd0, 32'd0, 8'h40, 1, mk(0, 0, 0, 0, 0, ST_NO_RUNNING));
      row(OP_START, 4'd0, 32'hffff_ffff, 8'h00);
      row(OP_BYTE, 4'd0, 32'd0, 8'hff);                          // max delta
      row(OP_BYTE, 4'd0, 32'd0, 8'hff);
      row(OP_BYTE, 4'd0, 32'd0, 8'hff);
      row(OP_BYTE, 4'd0, 32'd0, 8'h7f);
      row(OP_BYTE, 4'd0, 32'd0, 8'hff);                          // meta, zero length
      row(OP_BYTE, 4'd0, 32'd0, 8'h2f);
      row(OP_BYTE, 4'd0, 32'd0, 8'h00);
      row(OP_BYTE, 4'd0, 32'd0, 8'h00);
      row(OP_BYTE, 4'd0, 32'd0, 8'hc5);                          // program change
      row(OP_BYTE, 4'd0, 32'd0, 8'h7f);
      row(OP_BYTE, 4'd0, 32'd0, 8'h00);
      row(OP_BYTE, 4'd0, 32'd0, 8'h12);                          // running status
      row(OP_BYTE, 4'd0, 32'd0, 8'h00);
      row(OP_BYTE, 4'd0, 32'd0, 8'hf5, 1, mk(0, 32'h0fff_ffff, 0, 0, 0, ST_BAD_STATUS));
      row(OP_START, 4'd0, 32'd2, 8'h00);
      row(OP_BYTE, 4'd0, 32'd0, 8'h80);
      row(OP_BYTE, 4'd0, 32'd0, 8'h81);
      row(OP_BYTE, 4'd0, 32'd0, 8'h00, 1, mk(0, 0, 0, 0, 0, ST_PAST_END));
      foreach (directed[i]) begin
         if (directed[i].has_golden) begin
            send(directed[i].op, directed[i].track, directed[i].track_length,
                 directed[i].data_byte);
            if (pending_events.size() == 0 || pending_events[$] != directed[i].golden)
               report($sformatf("directed row %0d prediction off", i));
         end else begin
            send(directed[i].op, directed[i].track, directed[i].track_length,
                 directed[i].data_byte);
         end
      end
      drain();

      // Long varlen and tick saturation on track 0, sysex with long length.
      send(OP_START, 4'd0, 32'hffff_ffff, 8'h00);
      for (int i = 0; i < 4; i++) send(OP_BYTE, 4'd0, 0, 8'h80);
      send(OP_START, 4'd0, 32'hffff_ffff, 8'h00);
      for (int j = 0; j < 20; j++) begin
         for (int i = 0; i < 3; i++) send(OP_BYTE, 4'd0, 0, 8'hff);
         send(OP_BYTE, 4'd0, 0, 8'h7f);
         send(OP_BYTE, 4'd0, 0, 8'hd3);
         send(OP_BYTE, 4'd0, 0, 8'h01);
      end
      send(OP_BYTE, 4'd0, 0, 8'h00);
      send(OP_BYTE, 4'd0, 0, SYSEX_F0);
      for (int i = 0; i < 4; i++) send(OP_BYTE, 4'd0, 0, 8'hff);
      drain();

      // Random phases through several track counts, extremes included.
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: ntr = 16;
            1: ntr = 1;
            2: ntr = 31;
            3: ntr = $urandom_range(2, 15);
            default: ntr = 0;
         endcase
         write_tracks(5'(ntr));
         if (ph == 4) begin
            tx_idle_off = 1'b1;
            rx_idle_off = 1'b1;
            write_tracks(5'd16);
         end
         for (int i = 0; i < 16; i++)
            send(OP_START, 4'(i), ($urandom_range(0, 9) == 0) ? 32'($urandom_range(0, 20))
                 : 32'hffff_fff0 | 32'($urandom), 8'($urandom));
         for (int e = 0; e < 15; e++) begin
            t = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
            if (trk_halted[t] && $urandom_range(0, 1) == 0)
               send(OP_START, t, ($urandom_range(0, 7) == 0) ? 32'($urandom_range(0, 9))
                    : 32'hffff_ffff - 32'($urandom_range(0, 255)), 8'($urandom));
            random_event(t);
            if (e == 8 && ph == 1) begin
               // sender holds until the queue is empty
               req_push <= 1'b0;
               while (pending_events.size() != 0) @(posedge clock);
            end
         end
         drain();
      end

      $display("covered %0d input transfers, %0d results, track counts 0..31",
               items_sent, events_seen);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches", error_count);
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
